// ===== hw/rtl/btp_pkg.sv =====
// ----------------------------------------------------------------------------
// btp_pkg: shared types and constants for the B+tree page parser
// Input and result structs, parse phases, status codes and the page magic.
// ----------------------------------------------------------------------------
package btp_pkg;

  // Result queue depth; it must hold at least the two results of one byte
  localparam int unsigned RES_DEPTH = 4;

  // Page magic length and per-field byte counts
  localparam logic [4:0] MAGIC_LEN    = 5'd6;
  localparam logic [4:0] NKEYS_LEN    = 5'd2;
  localparam logic [4:0] ROOTCNT_LEN  = 5'd8;
  localparam logic [4:0] CHILD_LEN    = 5'd20;
  localparam logic [4:0] CHILD_W0_END = 5'd8;
  localparam logic [4:0] CHILD_W1_END = 5'd16;

  // Height byte layout
  localparam logic [7:0] ROOT_MASK   = 8'h80;
  localparam logic [7:0] HEIGHT_MASK = 8'h7f;

  // Result kinds
  localparam logic KIND_CHILD   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Page status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_TRUNC     = 2'd2;
  localparam logic [1:0] ST_PADDING   = 2'd3;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_NKEYS,
    PH_HEIGHT,
    PH_PREFIX,
    PH_ROOTCNT,
    PH_KLEN,
    PH_KDATA,
    PH_VLEN,
    PH_VDATA,
    PH_CHILD,
    PH_PAD,
    PH_ERR
  } phase_e;

  typedef struct packed {
    logic [7:0] page_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] child_page;
    logic [63:0] child_oldest_leaf;
    logic [31:0] child_size;
    logic [15:0] key_count;
    logic [6:0]  tree_height;
    logic        is_root;
    logic [7:0]  prefix_len;
    logic [63:0] node_total;
    logic [1:0]  status;
    logic        last_result;
  } out_item_t;

  // Expected magic byte at a given position
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h4b;
      3'd1:    val = 8'h56;
      3'd2:    val = 8'h4c;
      3'd3:    val = 8'h44;
      3'd4:    val = 8'h53;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/btp_result_fifo.sv =====
// ----------------------------------------------------------------------------
// btp_result_fifo: result queue with two write slots and one read port
// Takes up to two results per cycle in order and hands out one per cycle.
// ----------------------------------------------------------------------------
module btp_result_fifo #(
  parameter int unsigned DEPTH = btp_pkg::RES_DEPTH,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push0_i,
  input  logic              push1_i,
  input  btp_pkg::out_item_t data0_i,
  input  btp_pkg::out_item_t data1_i,
  input  logic              pop_i,
  output btp_pkg::out_item_t data_o,
  output logic [CW-1:0]     count_o
);

  btp_pkg::out_item_t mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, wptr_n1, wptr_n2;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Advance pointers and occupancy
  always_comb begin
    wptr_n1 = ptr_inc(wptr_q);
    wptr_n2 = ptr_inc(wptr_n1);
    wptr_d  = wptr_q;
    if (push0_i && push1_i) begin
      wptr_d = wptr_n2;
    end else if (push0_i) begin
      wptr_d = wptr_n1;
    end
    rptr_d  = pop_i ? ptr_inc(rptr_q) : rptr_q;
    count_d = count_q + CW'(push0_i) + CW'(push0_i && push1_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wptr_q] <= data0_i;
    end
    if (push0_i && push1_i) begin
      mem_q[wptr_n1] <= data1_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/btree_page_parser_top.sv =====
// ----------------------------------------------------------------------------
// btree_page_parser_top: streaming B+tree page parser
// Checks the page header, walks keys, values and child records, and reports
// each child record and a closing page summary.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o   | in_data_i  (byte, last)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (child/summary)
//
// One page byte is taken per cycle while in_stall_o is low; the parse state updates in that cycle.
// A byte yields zero, one or two results, which enter a RES_DEPTH-entry
// result queue; out_valid_o rises the cycle after a byte that yields a result is taken.
// in_stall_o rises while fewer than two queue slots are free.
// Reset is asynchronous, active low, and returns the parser to the magic.
// ----------------------------------------------------------------------------
module btree_page_parser_top #(
  parameter int unsigned RES_DEPTH = btp_pkg::RES_DEPTH,
  localparam int unsigned CW = $clog2(RES_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  btp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output btp_pkg::out_item_t out_data_o
);

  btp_pkg::phase_e phase_q, phase_d;
  logic [4:0]  fidx_q, fidx_d;
  logic [15:0] keys_q, keys_d;
  logic [16:0] items_q, items_d;
  logic [7:0]  entry_q, entry_d;
  logic [6:0]  height_q, height_d;
  logic        root_q, root_d;
  logic [7:0]  prefix_q, prefix_d;
  logic [63:0] ntotal_q, ntotal_d;
  logic [63:0] acc0_q, acc0_d;
  logic [63:0] acc1_q, acc1_d;
  logic [31:0] acc2_q, acc2_d;
  logic [1:0]  err_q, err_d;

  logic        in_acc;
  logic [7:0]  b;
  logic        last;
  logic        hdr_done, ent_end, keys_done, is_key, child_v;
  logic [7:0]  entry_dec;
  logic [16:0] items_dec;
  logic [1:0]  sum_status;
  btp_pkg::out_item_t child_rec, summary_rec;
  logic [CW-1:0] count;

  assign in_acc = in_valid_i && !in_stall_o;
  assign b      = in_data_i.page_byte;
  assign last   = in_data_i.last_byte;

  // Per-byte parse step
  always_comb begin
    phase_d   = phase_q;
    fidx_d    = fidx_q;
    keys_d    = keys_q;
    items_d   = items_q;
    entry_d   = entry_q;
    height_d  = height_q;
    root_d    = root_q;
    prefix_d  = prefix_q;
    ntotal_d  = ntotal_q;
    acc0_d    = acc0_q;
    acc1_d    = acc1_q;
    acc2_d    = acc2_q;
    err_d     = err_q;
    hdr_done  = 1'b0;
    ent_end   = 1'b0;
    keys_done = 1'b0;
    child_v   = 1'b0;
    is_key    = (phase_q == btp_pkg::PH_KLEN) || (phase_q == btp_pkg::PH_KDATA);
    entry_dec = (entry_q != 8'd0) ? entry_q - 8'd1 : 8'd0;
    items_dec = (items_q != 17'd0) ? items_q - 17'd1 : 17'd0;

    unique case (phase_q)
      btp_pkg::PH_MAGIC: begin
        if (fidx_q >= btp_pkg::MAGIC_LEN || b != btp_pkg::magic_byte(fidx_q[2:0])) begin
          err_d   = btp_pkg::ST_BAD_MAGIC;
          phase_d = btp_pkg::PH_ERR;
        end else if (fidx_q == btp_pkg::MAGIC_LEN - 5'd1) begin
          fidx_d  = '0;
          phase_d = btp_pkg::PH_NKEYS;
        end else begin
          fidx_d = fidx_q + 5'd1;
        end
      end
      btp_pkg::PH_NKEYS: begin
        keys_d = {keys_q[7:0], b};
        if (fidx_q >= btp_pkg::NKEYS_LEN - 5'd1) begin
          fidx_d  = '0;
          phase_d = btp_pkg::PH_HEIGHT;
        end else begin
          fidx_d = fidx_q + 5'd1;
        end
      end
      btp_pkg::PH_HEIGHT: begin
        root_d   = |(b & btp_pkg::ROOT_MASK);
        height_d = 7'(b & btp_pkg::HEIGHT_MASK);
        phase_d  = btp_pkg::PH_PREFIX;
      end
      btp_pkg::PH_PREFIX: begin
        prefix_d = b;
        if (root_q) begin
          fidx_d  = '0;
          phase_d = btp_pkg::PH_ROOTCNT;
        end else begin
          hdr_done = 1'b1;
        end
      end
      btp_pkg::PH_ROOTCNT: begin
        ntotal_d = {ntotal_q[55:0], b};
        if (fidx_q >= btp_pkg::ROOTCNT_LEN - 5'd1) begin
          fidx_d   = '0;
          hdr_done = 1'b1;
        end else begin
          fidx_d = fidx_q + 5'd1;
        end
      end
      btp_pkg::PH_KLEN, btp_pkg::PH_VLEN: begin
        if (b == 8'd0) begin
          ent_end = 1'b1;
        end else begin
          entry_d = b;
          phase_d = is_key ? btp_pkg::PH_KDATA : btp_pkg::PH_VDATA;
        end
      end
      btp_pkg::PH_KDATA, btp_pkg::PH_VDATA: begin
        entry_d = entry_dec;
        ent_end = (entry_dec == 8'd0);
      end
      btp_pkg::PH_CHILD: begin
        if (fidx_q < btp_pkg::CHILD_W0_END) begin
          acc0_d = {acc0_q[55:0], b};
        end else if (fidx_q < btp_pkg::CHILD_W1_END) begin
          acc1_d = {acc1_q[55:0], b};
        end else begin
          acc2_d = {acc2_q[23:0], b};
        end
        if (fidx_q >= btp_pkg::CHILD_LEN - 5'd1) begin
          child_v = 1'b1;
          fidx_d  = '0;
          acc0_d  = '0;
          acc1_d  = '0;
          acc2_d  = '0;
          items_d = items_dec;
          if (items_dec == 17'd0) begin
            phase_d = btp_pkg::PH_PAD;
          end
        end else begin
          fidx_d = fidx_q + 5'd1;
        end
      end
      btp_pkg::PH_PAD: begin
        if (b != 8'd0) begin
          err_d   = btp_pkg::ST_PADDING;
          phase_d = btp_pkg::PH_ERR;
        end
      end
      btp_pkg::PH_ERR: begin
        phase_d = btp_pkg::PH_ERR;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    // Header finished: enter the keys, or skip them when there are none
    if (hdr_done) begin
      if (keys_q == 16'd0) begin
        keys_done = 1'b1;
      end else begin
        phase_d = btp_pkg::PH_KLEN;
        items_d = {1'b0, keys_q};
      end
    end

    // Key or value finished: next entry, or close the section
    if (ent_end) begin
      items_d = items_dec;
      if (items_dec == 17'd0) begin
        if (is_key) begin
          keys_done = 1'b1;
        end else begin
          phase_d = btp_pkg::PH_PAD;
        end
      end else begin
        phase_d = is_key ? btp_pkg::PH_KLEN : btp_pkg::PH_VLEN;
      end
    end

    // Keys finished: values for a leaf, child records for a parent
    if (keys_done) begin
      if (height_q == 7'd0) begin
        if (keys_q == 16'd0) begin
          phase_d = btp_pkg::PH_PAD;
        end else begin
          phase_d = btp_pkg::PH_VLEN;
          items_d = {1'b0, keys_q};
        end
      end else begin
        phase_d = btp_pkg::PH_CHILD;
        items_d = {1'b0, keys_q} + 17'd1;
        fidx_d  = '0;
        acc0_d  = '0;
        acc1_d  = '0;
        acc2_d  = '0;
      end
    end
  end

  // Build the child record and the page summary
  always_comb begin
    priority if (phase_d == btp_pkg::PH_ERR) begin
      sum_status = err_d;
    end else if (phase_d != btp_pkg::PH_PAD) begin
      sum_status = btp_pkg::ST_TRUNC;
    end else begin
      sum_status = btp_pkg::ST_OK;
    end

    child_rec                   = '0;
    child_rec.kind              = btp_pkg::KIND_CHILD;
    child_rec.child_page        = acc0_q;
    child_rec.child_oldest_leaf = acc1_q;
    child_rec.child_size        = {acc2_q[23:0], b};

    summary_rec             = '0;
    summary_rec.kind        = btp_pkg::KIND_SUMMARY;
    summary_rec.key_count   = keys_d;
    summary_rec.tree_height = height_d;
    summary_rec.is_root     = root_d;
    summary_rec.prefix_len  = prefix_d;
    summary_rec.node_total  = ntotal_d;
    summary_rec.status      = sum_status;
    summary_rec.last_result = 1'b1;
  end

  // Commit the step; the last byte returns the parser to its reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= btp_pkg::PH_MAGIC;
      fidx_q   <= '0;
      keys_q   <= '0;
      items_q  <= '0;
      entry_q  <= '0;
      height_q <= '0;
      root_q   <= 1'b0;
      prefix_q <= '0;
      ntotal_q <= '0;
      acc0_q   <= '0;
      acc1_q   <= '0;
      acc2_q   <= '0;
      err_q    <= '0;
    end else if (in_acc) begin
      if (last) begin
        phase_q  <= btp_pkg::PH_MAGIC;
        fidx_q   <= '0;
        keys_q   <= '0;
        items_q  <= '0;
        entry_q  <= '0;
        height_q <= '0;
        root_q   <= 1'b0;
        prefix_q <= '0;
        ntotal_q <= '0;
        acc0_q   <= '0;
        acc1_q   <= '0;
        acc2_q   <= '0;
        err_q    <= '0;
      end else begin
        phase_q  <= phase_d;
        fidx_q   <= fidx_d;
        keys_q   <= keys_d;
        items_q  <= items_d;
        entry_q  <= entry_d;
        height_q <= height_d;
        root_q   <= root_d;
        prefix_q <= prefix_d;
        ntotal_q <= ntotal_d;
        acc0_q   <= acc0_d;
        acc1_q   <= acc1_d;
        acc2_q   <= acc2_d;
        err_q    <= err_d;
      end
    end
  end

  // Queue results; the summary follows a child record from the same byte
  logic push0, push1;
  btp_pkg::out_item_t push0_data;

  assign push0      = in_acc && (child_v || last);
  assign push1      = in_acc && child_v && last;
  assign push0_data = child_v ? child_rec : summary_rec;

  btp_result_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .push1_i (push1),
    .data0_i (push0_data),
    .data1_i (summary_rec),
    .pop_i   (out_valid_o && !out_stall_i),
    .data_o  (out_data_o),
    .count_o (count)
  );

  // Hold off input while two slots are not free
  assign in_stall_o  = (count > CW'(RES_DEPTH - 2));
  assign out_valid_o = (count != '0);

  // Checks
  a_summary_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> out_valid_o)
    else $error("page summary not queued");

  a_page_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last |=> phase_q == btp_pkg::PH_MAGIC && fidx_q == 5'd0)
    else $error("parser did not restart after last byte");

  a_magic_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == btp_pkg::PH_MAGIC |-> fidx_q < btp_pkg::MAGIC_LEN)
    else $error("magic index out of range");

  a_child_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == btp_pkg::PH_CHILD |-> fidx_q < btp_pkg::CHILD_LEN && items_q != 17'd0)
    else $error("child record state inconsistent");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(RES_DEPTH))
    else $error("result queue overflow");

endmodule
